FILE: rtl/grc_pkg.sv
// Shared types, constants and tables for the grid ray caster.
`default_nettype none
package grc_pkg;

  localparam int MapSize  = 32;
  localparam int FracBits = 16;
  localparam int AddrW    = 10;                 // log2(MapSize * MapSize)
  localparam int MapDepth = MapSize * MapSize;
  localparam int CordicN  = 30;
  localparam int DivNW    = 48;                 // dividend width of the divider
  localparam int DivDW    = 31;                 // divisor width
  localparam int SqrtRW   = 44;                 // radicand width
  localparam int SqrtQW   = SqrtRW / 2;         // root width
  localparam int MaxSteps = MapSize + 2;

  localparam logic [5:0]  MAP_SIZE_C = 6'd32;
  localparam logic [5:0]  MAX_STEPS_C = 6'd34;
  localparam logic [30:0] ONE_DIR    = 31'h4000_0000;
  localparam logic [33:0] CORDIC_K   = 34'd652032874;
  localparam logic [21:0] DIST_MAX   = 22'h3F_FFFF;

  // Command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_CAST  = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_MAP_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_MAP_HEIGHT = 2'd1;

  // Arctangent table in units of 2^-32 turn
  localparam logic [29:0] GRC_ATAN [0:CordicN-1] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
    30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
    30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1
  };

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIR_GO,
    ST_DIR_WAIT,
    ST_FAM,
    ST_OFF_MUL,
    ST_OFF_DIV_GO,
    ST_OFF_DIV_WAIT,
    ST_STEP_DIV_GO,
    ST_STEP_DIV_WAIT,
    ST_ITER_CHK,
    ST_ITER_RD,
    ST_SQ_A,
    ST_SQ_B,
    ST_SQ_SUM,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_NEXT_FAM,
    ST_DONE
  } grc_state_t;

endpackage
`default_nettype wire

FILE: rtl/grc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module grc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/grc_cordic.sv
// Iterative CORDIC giving the ray direction, one micro-rotation per cycle.
`default_nettype none
module grc_cordic import grc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [15:0]        angle,
  output logic                    done,
  output logic signed [31:0]      cos_x,
  output logic signed [31:0]      sin_y
);

  logic               busy_r;
  logic [4:0]         i_r;
  logic [1:0]         quad_r;
  logic signed [33:0] x_r, y_r, x_nxt, y_nxt;
  logic signed [32:0] z_r, z_nxt;
  logic signed [33:0] xs, ys;
  logic signed [32:0] at;
  logic               done_r;
  logic signed [31:0] cx_r, sy_r;
  logic [30:0]        c_cl, s_cl;
  logic signed [31:0] cx_nxt, sy_nxt;

  // One micro-rotation
  always_comb begin
    xs = x_r >>> i_r;
    ys = y_r >>> i_r;
    at = $signed({3'b000, GRC_ATAN[i_r]});
    if (!z_r[32]) begin
      x_nxt = x_r - ys;
      y_nxt = y_r + xs;
      z_nxt = z_r - at;
    end else begin
      x_nxt = x_r + ys;
      y_nxt = y_r - xs;
      z_nxt = z_r + at;
    end
  end

  // Clamp to 0..1 and place by quadrant
  always_comb begin
    if (x_nxt[33]) c_cl = '0;
    else if (x_nxt > $signed({3'b000, ONE_DIR})) c_cl = ONE_DIR;
    else c_cl = x_nxt[30:0];
    if (y_nxt[33]) s_cl = '0;
    else if (y_nxt > $signed({3'b000, ONE_DIR})) s_cl = ONE_DIR;
    else s_cl = y_nxt[30:0];
    case (quad_r)
      2'd0: begin cx_nxt = $signed({1'b0, c_cl});  sy_nxt = $signed({1'b0, s_cl});  end
      2'd1: begin cx_nxt = -$signed({1'b0, s_cl}); sy_nxt = $signed({1'b0, c_cl});  end
      2'd2: begin cx_nxt = -$signed({1'b0, c_cl}); sy_nxt = -$signed({1'b0, s_cl}); end
      default: begin cx_nxt = $signed({1'b0, s_cl}); sy_nxt = -$signed({1'b0, c_cl}); end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        // Quarter-turn multiples give exact axis vectors
        if (angle[13:0] == 14'd0) begin
          done_r <= 1'b1;
          case (angle[15:14])
            2'd0: begin cx_r <= 32'sh4000_0000;  sy_r <= '0; end
            2'd1: begin cx_r <= '0;  sy_r <= 32'sh4000_0000; end
            2'd2: begin cx_r <= -32'sh4000_0000; sy_r <= '0; end
            default: begin cx_r <= '0; sy_r <= -32'sh4000_0000; end
          endcase
        end else begin
          busy_r <= 1'b1;
        end
        quad_r <= angle[15:14];
        z_r    <= $signed({3'b000, angle[13:0], 16'h0000});
        x_r    <= $signed(CORDIC_K);
        y_r    <= '0;
        i_r    <= '0;
      end else if (busy_r) begin
        x_r <= x_nxt;
        y_r <= y_nxt;
        z_r <= z_nxt;
        i_r <= i_r + 5'd1;
        if (i_r == 5'(CordicN - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          cx_r   <= cx_nxt;
          sy_r   <= sy_nxt;
        end
      end
    end
  end

  assign done  = done_r;
  assign cos_x = cx_r;
  assign sin_y = sy_r;

endmodule
`default_nettype wire

FILE: rtl/grc_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module grc_div import grc_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DivNW-1:0] dividend,
  input  wire logic [DivDW-1:0] divisor,
  output logic                  done,
  output logic      [DivNW-1:0] quotient
);

  logic             busy_r, done_r;
  logic [5:0]       cnt_r;
  logic [DivDW:0]   rem_r;
  logic [DivNW-1:0] quo_r;
  logic [DivDW-1:0] dvs_r;
  logic [DivDW:0]   trial;
  logic             fits;

  always_comb begin
    trial = {rem_r[DivDW-1:0], quo_r[DivNW-1]};
    fits  = trial >= {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        quo_r  <= dividend;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= fits ? trial - {1'b0, dvs_r} : trial;
        quo_r <= {quo_r[DivNW-2:0], fits};
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'(DivNW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

FILE: rtl/grc_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
`default_nettype none
module grc_sqrt import grc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [SqrtRW-1:0] radicand,
  output logic                   done,
  output logic      [SqrtQW-1:0] root
);

  logic              busy_r, done_r;
  logic [4:0]        cnt_r;
  logic [SqrtRW-1:0] rad_r;
  logic [SqrtQW+1:0] rem_r, trial, cand;
  logic [SqrtQW-1:0] root_r;
  logic              fits;

  always_comb begin
    trial = {rem_r[SqrtQW-1:0], rad_r[SqrtRW-1 -: 2]};
    cand  = {root_r, 2'b01};
    fits  = trial >= cand;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rad_r  <= radicand;
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        rem_r  <= fits ? trial - cand : trial;
        root_r <= {root_r[SqrtQW-2:0], fits};
        rad_r  <= {rad_r[SqrtRW-3:0], 2'b00};
        cnt_r  <= cnt_r + 5'd1;
        if (cnt_r == 5'(SqrtQW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule
`default_nettype wire

FILE: rtl/grid_ray_cast_distance.sv
// Top level of the grid ray caster: sequencer, shared multiplier and wall map.
//
// Ray caster over a 32 x 32 one-bit wall map. A write command stores one cell
// and is done at once; a cast command produces one result, shown for a single
// cycle with out_valid high, which the receiver must take there and then.
// After reset the map is cleared with busy held high. A cast runs the CORDIC
// (a shortcut on an exact quarter turn), then per grid-line family that the
// ray crosses two divisions of setup, a map read per line stepped and
// squaring and a square root on a hit; a family the ray runs parallel to is
// skipped. Configuration writes are taken at any time.
`default_nettype none
module grid_ray_cast_distance import grc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_cmd,
  input  wire logic [4:0]  in_cell_x,
  input  wire logic [4:0]  in_cell_y,
  input  wire logic        in_cell_wall,
  input  wire logic [20:0] in_pos_x,
  input  wire logic [20:0] in_pos_y,
  input  wire logic [15:0] in_ray_angle,
  output logic             out_valid,
  output logic [21:0]      out_distance,
  output logic             out_hit,
  output logic             out_hit_side,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [5:0]  cfg_data
);

  grc_state_t state_r, state_nxt;

  logic [5:0]         width_r, height_r, w_use, h_use;
  logic [AddrW-1:0]   clr_r;
  logic [20:0]        px_r, py_r;
  logic [15:0]        angle_r;
  logic signed [31:0] dx_r, dy_r;
  logic               fam_r;
  logic signed [6:0]  line_r;
  logic signed [51:0] o_r, step_r;
  logic [5:0]         n_r;
  logic               hh_r, hv_r;
  logic [21:0]        dh_r, dv_r;
  logic [61:0]        mul_r;
  logic [43:0]        acc_r;
  logic               out_valid_r, out_hit_r, out_side_r;
  logic [21:0]        out_dist_r;

  // Family selection
  logic [20:0]        pa, po;
  logic signed [31:0] da, dor;
  logic [5:0]         lima, limo;
  logic [30:0]        ada, adr;
  logic               da_pos;
  logic signed [6:0]  line_init, ca;
  logic signed [23:0] off_s;
  logic [22:0]        off_abs;
  logic signed [21:0] b_s;
  logic [20:0]        b_abs;
  logic               leave;
  logic [4:0]         co5;

  // Sequencer outputs
  logic               cor_start, div_start, sq_start;
  logic [DivNW-1:0]   div_dividend;
  logic [30:0]        mul_a, mul_b;
  logic [AddrW-1:0]   raddr, waddr;
  logic               we, wdata;

  // Unit results
  logic               cor_done, div_done, sq_done;
  logic signed [31:0] cor_cx, cor_sy;
  logic [DivNW-1:0]   quo;
  logic [SqrtQW-1:0]  root;
  logic               rdata;
  logic signed [51:0] quo_s;
  logic               accept;

  assign accept = start && (state_r == ST_IDLE);

  // Map size clamped to the array
  assign w_use = (width_r  > MAP_SIZE_C) ? MAP_SIZE_C : width_r;
  assign h_use = (height_r > MAP_SIZE_C) ? MAP_SIZE_C : height_r;

  // Current family: 0 steps across y lines, 1 across x lines
  always_comb begin
    pa   = fam_r ? px_r  : py_r;
    po   = fam_r ? py_r  : px_r;
    da   = fam_r ? dx_r  : dy_r;
    dor  = fam_r ? dy_r  : dx_r;
    lima = fam_r ? w_use : h_use;
    limo = fam_r ? h_use : w_use;
    ada  = da[31]  ? 31'(-da)  : da[30:0];
    adr  = dor[31] ? 31'(-dor) : dor[30:0];
    da_pos = !da[31] && (da != 32'sd0);
    line_init = $signed({2'b00, pa[20:16]}) + (da_pos ? 7'sd1 : 7'sd0);
    off_s   = $signed({line_r[6], line_r, 16'h0000}) - $signed({3'b000, pa});
    off_abs = off_s[23] ? 23'(-off_s) : off_s[22:0];
    b_s     = $signed({1'b0, o_r[20:0]}) - $signed({1'b0, po});
    b_abs   = b_s[21] ? 21'(-b_s) : b_s[20:0];
    ca      = da_pos ? line_r : line_r - 7'sd1;
    co5     = o_r[20:16];
    leave   = (n_r == MAX_STEPS_C) || ca[6] || ({1'b0, ca[5:0]} >= {1'b0, lima}) ||
              o_r[51] || (o_r[51:16] >= {30'd0, limo});
    quo_s   = dor[31] ? -$signed({4'b0000, quo}) : $signed({4'b0000, quo});
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:         if (clr_r == '1) state_nxt = ST_IDLE;
      ST_IDLE:          if (start && in_cmd == CMD_CAST) state_nxt = ST_DIR_GO;
      ST_DIR_GO:        state_nxt = ST_DIR_WAIT;
      ST_DIR_WAIT:      if (cor_done) state_nxt = ST_FAM;
      ST_FAM:           state_nxt = (ada == '0) ? ST_NEXT_FAM : ST_OFF_MUL;
      ST_OFF_MUL:       state_nxt = ST_OFF_DIV_GO;
      ST_OFF_DIV_GO:    state_nxt = ST_OFF_DIV_WAIT;
      ST_OFF_DIV_WAIT:  if (div_done) state_nxt = ST_STEP_DIV_GO;
      ST_STEP_DIV_GO:   state_nxt = ST_STEP_DIV_WAIT;
      ST_STEP_DIV_WAIT: if (div_done) state_nxt = ST_ITER_CHK;
      ST_ITER_CHK:      state_nxt = leave ? ST_NEXT_FAM : ST_ITER_RD;
      ST_ITER_RD:       state_nxt = rdata ? ST_SQ_A : ST_ITER_CHK;
      ST_SQ_A:          state_nxt = ST_SQ_B;
      ST_SQ_B:          state_nxt = ST_SQ_SUM;
      ST_SQ_SUM:        state_nxt = ST_SQRT_GO;
      ST_SQRT_GO:       state_nxt = ST_SQRT_WAIT;
      ST_SQRT_WAIT:     if (sq_done) state_nxt = ST_NEXT_FAM;
      ST_NEXT_FAM:      state_nxt = fam_r ? ST_DONE : ST_FAM;
      ST_DONE:          state_nxt = ST_IDLE;
      default:          state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    cor_start    = 1'b0;
    div_start    = 1'b0;
    sq_start     = 1'b0;
    div_dividend = mul_r[DivNW-1:0];
    mul_a        = '0;
    mul_b        = '0;
    raddr        = fam_r ? {ca[4:0], co5} : {co5, ca[4:0]};
    we           = 1'b0;
    waddr        = {in_cell_x, in_cell_y};
    wdata        = in_cell_wall;
    case (state_r)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_r;
        wdata = 1'b0;
      end
      ST_IDLE:        we = start && (in_cmd == CMD_WRITE);
      ST_DIR_GO:      cor_start = 1'b1;
      ST_OFF_MUL: begin
        mul_a = {8'd0, off_abs};
        mul_b = adr;
      end
      ST_OFF_DIV_GO:  div_start = 1'b1;
      ST_STEP_DIV_GO: begin
        div_start    = 1'b1;
        div_dividend = {1'b0, adr, 16'h0000};
      end
      ST_SQ_A: begin
        mul_a = {8'd0, off_abs};
        mul_b = {8'd0, off_abs};
      end
      ST_SQ_B: begin
        mul_a = {10'd0, b_abs};
        mul_b = {10'd0, b_abs};
      end
      ST_SQRT_GO:     sq_start = 1'b1;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      width_r     <= 6'd24;
      height_r    <= 6'd24;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_DONE);
      if (state_r == ST_CLEAR) clr_r <= clr_r + 1'b1;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_MAP_WIDTH)  width_r  <= cfg_data;
        if (cfg_index == CFG_MAP_HEIGHT) height_r <= cfg_data;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    mul_r <= mul_a * mul_b;
    if (accept) begin
      px_r    <= in_pos_x;
      py_r    <= in_pos_y;
      angle_r <= in_ray_angle;
      hh_r    <= 1'b0;
      hv_r    <= 1'b0;
      fam_r   <= 1'b0;
    end
    case (state_r)
      ST_DIR_WAIT: if (cor_done) begin
        dx_r <= cor_cx;
        dy_r <= cor_sy;
      end
      ST_FAM: begin
        line_r <= line_init;
        n_r    <= '0;
      end
      ST_OFF_DIV_WAIT: if (div_done) o_r <= $signed({31'd0, po}) + quo_s;
      ST_STEP_DIV_WAIT: if (div_done) step_r <= quo_s;
      ST_ITER_RD: if (!rdata) begin
        line_r <= da_pos ? line_r + 7'sd1 : line_r - 7'sd1;
        o_r    <= o_r + step_r;
        n_r    <= n_r + 6'd1;
      end
      ST_SQ_B:   acc_r <= mul_r[43:0];
      ST_SQ_SUM: acc_r <= acc_r + mul_r[43:0];
      ST_SQRT_WAIT: if (sq_done) begin
        if (fam_r) begin
          hv_r <= 1'b1;
          dv_r <= root;
        end else begin
          hh_r <= 1'b1;
          dh_r <= root;
        end
      end
      ST_NEXT_FAM: fam_r <= 1'b1;
      ST_DONE: begin
        out_hit_r <= hh_r || hv_r;
        if (hh_r && hv_r) begin
          out_dist_r <= (dv_r < dh_r) ? dv_r : dh_r;
          out_side_r <= (dv_r < dh_r);
        end else if (hh_r) begin
          out_dist_r <= dh_r;
          out_side_r <= 1'b0;
        end else if (hv_r) begin
          out_dist_r <= dv_r;
          out_side_r <= 1'b1;
        end else begin
          out_dist_r <= DIST_MAX;
          out_side_r <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  grc_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .angle (angle_r),
    .done  (cor_done),
    .cos_x (cor_cx),
    .sin_y (cor_sy)
  );

  grc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (ada),
    .done     (div_done),
    .quotient (quo)
  );

  grc_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (acc_r),
    .done     (sq_done),
    .root     (root)
  );

  grc_ram #(
    .WIDTH (1),
    .DEPTH (MapDepth)
  ) u_map (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign busy         = (state_r != ST_IDLE);
  assign cfg_ready    = 1'b1;
  assign out_valid    = out_valid_r;
  assign out_distance = out_dist_r;
  assign out_hit      = out_hit_r;
  assign out_hit_side = out_side_r;

endmodule
`default_nettype wire

FILE: test/grc_checker.sv
// Checker for the grid ray caster: predicts each cast result and compares it.
`timescale 1ns / 1ps
module grc_checker import grc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic        in_cmd,
  input  wire logic [4:0]  in_cell_x,
  input  wire logic [4:0]  in_cell_y,
  input  wire logic        in_cell_wall,
  input  wire logic [20:0] in_pos_x,
  input  wire logic [20:0] in_pos_y,
  input  wire logic [15:0] in_ray_angle,
  input  wire logic        out_valid,
  input  wire logic [21:0] out_distance,
  input  wire logic        out_hit,
  input  wire logic        out_hit_side,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [5:0]  cfg_data,
  output int               fail_count,
  output int               pending
);

  localparam int     FX       = 16;
  localparam longint ONE_FX   = 64'sd1 << FX;
  localparam longint UNIT_DIR = 64'sd1 << 30;
  localparam longint START_X  = 64'sd652032874;

  // Arctangent steps in units of 2^-32 turn
  localparam longint ATAN_STEP [30] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1
  };

  typedef struct packed {
    logic [21:0] distance;
    logic        hit;
    logic        hit_side;
  } cast_result_t;

  logic         wall_bits [MapDepth];
  logic [5:0]   width_reg;
  logic [5:0]   height_reg;
  cast_result_t expected_casts [$];

  assign pending = expected_casts.size();

  // Walks one family of grid lines; returns 1 with the distance on a wall.
  function automatic bit walk_lines(longint pa, longint po, longint da, longint dor,
                                    longint lima, longint limo, bit lines_are_x,
                                    output longint unsigned range_fx);
    longint ada, line, o, step, ca, co, cx, cy;
    longint unsigned a, b, v, res, probe;
    range_fx = 0;
    ada  = (da < 0) ? -da : da;
    if (ada == 0) return 0;
    line = (pa >>> FX) + ((da > 0) ? 1 : 0);
    a    = (line * ONE_FX - pa < 0) ? pa - line * ONE_FX : line * ONE_FX - pa;
    o    = po + (longint'(a) * dor) / ada;
    step = (ONE_FX * dor) / ada;
    for (int n = 0; n < MapSize + 2; n++) begin
      ca = (da > 0) ? line : line - 1;
      if (ca < 0 || ca >= lima || o < 0) return 0;
      co = o >>> FX;
      if (co >= limo) return 0;
      cx = lines_are_x ? ca : co;
      cy = lines_are_x ? co : ca;
      if (wall_bits[cx * MapSize + cy]) begin
        a = (line * ONE_FX - pa < 0) ? pa - line * ONE_FX : line * ONE_FX - pa;
        b = (o - po < 0) ? po - o : o - po;
        v = a * a + b * b;
        // integer square root, floor
        res   = 0;
        probe = 64'd1 << 62;
        while (probe > v) probe = probe >> 2;
        while (probe != 0) begin
          if (v >= res + probe) begin
            v   = v - (res + probe);
            res = (res >> 1) + probe;
          end else begin
            res = res >> 1;
          end
          probe = probe >> 2;
        end
        range_fx = res;
        return 1;
      end
      line = line + ((da > 0) ? 1 : -1);
      o    = o + step;
    end
    return 0;
  endfunction

  function automatic cast_result_t cast_ray(logic [20:0] px_in, logic [20:0] py_in,
                                            logic [15:0] angle);
    logic [31:0]     a32;
    logic [1:0]      quad;
    longint          z, x, y, xs, ys, c, s, dx, dy, px, py, w, h;
    longint unsigned dh, dv, near_fx;
    bit              hh, hv;
    cast_result_t    r;
    a32  = {angle, 16'h0000};
    quad = a32[31:30];
    z    = longint'(a32[29:0]);
    c    = UNIT_DIR;
    s    = 0;
    // CORDIC rotation within the quadrant
    if (z != 0) begin
      x = START_X;
      y = 0;
      for (int i = 0; i < 30; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x = x - ys; y = y + xs; z = z - ATAN_STEP[i];
        end else begin
          x = x + ys; y = y - xs; z = z + ATAN_STEP[i];
        end
      end
      c = (x < 0) ? 0 : ((x > UNIT_DIR) ? UNIT_DIR : x);
      s = (y < 0) ? 0 : ((y > UNIT_DIR) ? UNIT_DIR : y);
    end
    case (quad)
      2'd0:    begin dx = c;  dy = s;  end
      2'd1:    begin dx = -s; dy = c;  end
      2'd2:    begin dx = -c; dy = -s; end
      default: begin dx = s;  dy = -c; end
    endcase
    px = longint'(px_in);
    py = longint'(py_in);
    w  = (width_reg > MAP_SIZE_C) ? MapSize : longint'(width_reg);
    h  = (height_reg > MAP_SIZE_C) ? MapSize : longint'(height_reg);
    hh = walk_lines(py, px, dy, dx, h, w, 1'b0, dh);
    hv = walk_lines(px, py, dx, dy, w, h, 1'b1, dv);
    r.hit      = hh || hv;
    r.hit_side = 1'b0;
    if (hh && hv) begin
      near_fx = dh;
      if (dv < dh) begin near_fx = dv; r.hit_side = 1'b1; end
    end else if (hh) begin
      near_fx = dh;
    end else if (hv) begin
      near_fx = dv;
      r.hit_side = 1'b1;
    end else begin
      near_fx = DIST_MAX;
    end
    r.distance = (near_fx > DIST_MAX) ? DIST_MAX : near_fx[21:0];
    return r;
  endfunction

  // Track configuration, map writes and casts; compare results in order
  always @(posedge clk) begin
    cast_result_t want;
    if (!rst_n) begin
      width_reg  <= 6'd24;
      height_reg <= 6'd24;
      fail_count <= 0;
      expected_casts.delete();
      for (int i = 0; i < MapDepth; i++) wall_bits[i] = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_MAP_WIDTH) width_reg <= cfg_data;
        else if (cfg_index == CFG_MAP_HEIGHT) height_reg <= cfg_data;
      end
      if (start && !busy) begin
        if (in_cmd == CMD_WRITE)
          wall_bits[in_cell_x * MapSize + in_cell_y] = in_cell_wall;
        else
          expected_casts.push_back(cast_ray(in_pos_x, in_pos_y, in_ray_angle));
      end
      if (out_valid) begin
        if (expected_casts.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result: distance %0d hit %0b side %0b",
                     out_distance, out_hit, out_hit_side);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_casts.pop_front();
          if (want !== {out_distance, out_hit, out_hit_side}) begin
            if (fail_count < 10)
              $display("mismatch: exp distance %0d hit %0b side %0b, got %0d %0b %0b",
                       want.distance, want.hit, want.hit_side,
                       out_distance, out_hit, out_hit_side);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

FILE: test/grid_ray_cast_distance_tb.sv
// Testbench top for the grid ray caster: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module grid_ray_cast_distance_tb;
  import grc_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_cmd;
  logic [4:0]  in_cell_x;
  logic [4:0]  in_cell_y;
  logic        in_cell_wall;
  logic [20:0] in_pos_x;
  logic [20:0] in_pos_y;
  logic [15:0] in_ray_angle;
  logic        out_valid;
  logic [21:0] out_distance;
  logic        out_hit;
  logic        out_hit_side;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [5:0]  cfg_data;
  int          fail_count;
  int          pending;
  int          quiet_cycles;
  bit          no_gaps;
  int          cur_w;
  int          cur_h;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  grid_ray_cast_distance u_top (.*);

  grc_checker u_chk (.*);

  // Watchdog: cycles without any transaction
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic idle_gap();
    if (!no_gaps && $urandom_range(99) < 35) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic issue(logic cmd, logic [4:0] cx, logic [4:0] cy, logic wall,
                       logic [20:0] px, logic [20:0] py, logic [15:0] ang);
    start        <= 1'b1;
    in_cmd       <= cmd;
    in_cell_x    <= cx;
    in_cell_y    <= cy;
    in_cell_wall <= wall;
    in_pos_x     <= px;
    in_pos_y     <= py;
    in_ray_angle <= ang;
    do @(posedge clk); while (busy);
    idle_gap();
  endtask

  task automatic put_cell(int x, int y, logic wall);
    issue(CMD_WRITE, x[4:0], y[4:0], wall, 21'($urandom), 21'($urandom), 16'($urandom));
  endtask

  task automatic cast(logic [20:0] px, logic [20:0] py, logic [15:0] ang);
    issue(CMD_CAST, 5'($urandom), 5'($urandom), 1'($urandom), px, py, ang);
  endtask

  // Wait until every expected result is in and the block has settled
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [5:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_MAP_WIDTH) cur_w = int'(val);
    else if (idx == CFG_MAP_HEIGHT) cur_h = int'(val);
  endtask

  function automatic logic [20:0] coord_in(int lim);
    int l;
    l = (lim > 32) ? 32 : lim;
    if (l == 0 || $urandom_range(9) == 0) return 21'($urandom);
    return 21'($urandom_range((l << 16) - 1, 0));
  endfunction

  function automatic logic [15:0] pick_angle();
    int k;
    k = $urandom_range(9);
    if (k == 0) return 16'($urandom_range(3) << 14);
    if (k == 1) return 16'(($urandom_range(3) << 14) + $urandom_range(2) - 1);
    return 16'($urandom);
  endfunction

  // Random mix of map writes and casts for one phase
  task automatic random_phase(int n_items, int pause_at);
    int l;
    for (int i = 0; i < n_items; i++) begin
      if (i == pause_at) drain();
      l = (cur_w > 32) ? 32 : ((cur_w == 0) ? 32 : cur_w);
      if ($urandom_range(99) < 30) begin
        if ($urandom_range(9) == 0)
          put_cell($urandom_range(31), $urandom_range(31), 1'($urandom_range(1)));
        else
          put_cell($urandom_range(l - 1), $urandom_range(31),
                   $urandom_range(99) < 45);
      end else begin
        cast(coord_in(cur_w), coord_in(cur_h), pick_angle());
      end
    end
  endtask

  initial begin
    rst_n        <= 1'b0;
    start        <= 1'b0;
    in_cmd       <= CMD_WRITE;
    in_cell_x    <= '0;
    in_cell_y    <= '0;
    in_cell_wall <= 1'b0;
    in_pos_x     <= '0;
    in_pos_y     <= '0;
    in_ray_angle <= '0;
    cfg_valid    <= 1'b0;
    cfg_index    <= CFG_MAP_WIDTH;
    cfg_data     <= '0;
    quiet_cycles <= 0;
    no_gaps      = 1'b0;
    cur_w        = 24;
    cur_h        = 24;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty map, corners, axis-parallel rays, edges of the fields
    cast(21'h0C_0000, 21'h0C_0000, 16'h0000);
    put_cell(0, 0, 1'b1);
    put_cell(31, 31, 1'b1);
    put_cell(23, 12, 1'b1);
    put_cell(12, 23, 1'b1);
    put_cell(0, 12, 1'b1);
    put_cell(12, 0, 1'b1);
    cast(21'h0C_8000, 21'h0C_8000, 16'h0000);
    cast(21'h0C_8000, 21'h0C_8000, 16'h4000);
    cast(21'h0C_8000, 21'h0C_8000, 16'h8000);
    cast(21'h0C_8000, 21'h0C_8000, 16'hC000);
    cast(21'h0C_0000, 21'h0C_0000, 16'hFFFF);
    cast(21'h0C_0000, 21'h0C_0000, 16'h0001);
    cast(21'h01_8000, 21'h01_8000, 16'hA000);
    cast(21'h00_0000, 21'h00_0000, 16'h2000);
    cast(21'h1F_FFFF, 21'h1F_FFFF, 16'hA000);
    cast(21'h1F_FFFF, 21'h00_0000, 16'h7FFF);
    put_cell(23, 12, 1'b0);
    cast(21'h0C_8000, 21'h0C_8000, 16'h0000);
    drain();

    // Phases over several map sizes, extremes among them
    write_reg(CFG_MAP_WIDTH, 6'd32);
    write_reg(CFG_MAP_HEIGHT, 6'd32);
    put_cell(31, 0, 1'b1);
    cast(21'h1F_8000, 21'h10_0000, 16'hC000);
    cast(21'h00_8000, 21'h00_8000, 16'h0000);
    random_phase(300, 120);
    drain();
    write_reg(CFG_MAP_WIDTH, 6'd1);
    write_reg(2'd2, 6'd5);
    no_gaps = 1'b1;
    random_phase(300, -1);
    no_gaps = 1'b0;
    drain();
    write_reg(CFG_MAP_WIDTH, 6'd32);
    write_reg(CFG_MAP_HEIGHT, 6'd1);
    random_phase(250, -1);
    drain();
    write_reg(CFG_MAP_WIDTH, 6'd0);
    write_reg(2'd3, 6'd63);
    random_phase(100, -1);
    drain();
    write_reg(CFG_MAP_WIDTH, 6'd63);
    write_reg(CFG_MAP_HEIGHT, 6'd63);
    random_phase(400, -1);
    drain();
    write_reg(CFG_MAP_HEIGHT, 6'd0);
    random_phase(100, -1);
    drain();
    for (int p = 0; p < 3; p++) begin
      write_reg(CFG_MAP_WIDTH, 6'($urandom_range(1, 32)));
      write_reg(CFG_MAP_HEIGHT, 6'($urandom_range(1, 32)));
      random_phase(200, -1);
      drain();
    end

    // Tail: let anything late show up before the verdict
    repeat (500) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
